// ===== rtl/lsps_pkg.sv =====
// shared types, constants and chord table builder for the laser scan person segmenter
package lsps_pkg;

  localparam int MAX_SAMPLES     = 1024;
  localparam int ADDR_W          = $clog2(MAX_SAMPLES);
  localparam int IDX_W           = ADDR_W + 1;
  localparam int ANGLE_STEP_URAD = 6136;
  localparam int CHORD_FRAC_BITS = 14;
  localparam int CHORD_W         = CHORD_FRAC_BITS + 2;

  localparam int RANGE_W    = 16;
  localparam int THR_W      = 13;
  localparam int LEN_W      = 11;
  localparam int WIN_W      = 10;
  localparam int CNT_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // five-tap sum and its divide by five as multiply by reciprocal
  localparam int SUM_W      = RANGE_W + 3;
  localparam int MEAN_SHIFT = 21;
  localparam logic [SUM_W-1:0] MEAN_RECIP = SUM_W'(419431);

  localparam logic [RANGE_W-1:0] RST_RANGE_CLAMP = RANGE_W'(5400);
  localparam logic [THR_W-1:0]   RST_EDGE_THR    = THR_W'(500);
  localparam logic [RANGE_W-1:0] RST_MIN_CHORD   = RANGE_W'(180);
  localparam logic [RANGE_W-1:0] RST_MAX_CHORD   = RANGE_W'(600);
  localparam logic [LEN_W-1:0]   RST_SCAN_LEN    = LEN_W'(680);
  localparam logic [WIN_W-1:0]   RST_CENTRE_WIN  = WIN_W'(40);

  localparam logic KIND_CAND = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_CLAMP = 3'd0,
    CFG_EDGE_THR    = 3'd1,
    CFG_MIN_CHORD   = 3'd2,
    CFG_MAX_CHORD   = 3'd3,
    CFG_SCAN_LEN    = 3'd4,
    CFG_CENTRE_WIN  = 3'd5
  } lsps_cfg_idx_e;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               invalid;
    logic               last;
  } lsps_in_t;

  typedef struct packed {
    logic               kind;
    logic [ADDR_W-1:0]  centre_index;
    logic [ADDR_W-1:0]  seg_width;
    logic [RANGE_W-1:0] mean_range_mm;
    logic [CNT_W-1:0]   accepted_count;
  } lsps_out_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_clamp_mm;
    logic [THR_W-1:0]   edge_threshold_mm;
    logic [RANGE_W-1:0] min_chord_mm;
    logic [RANGE_W-1:0] max_chord_mm;
    logic [LEN_W-1:0]   scan_length;
    logic [WIN_W-1:0]   centre_window;
  } lsps_cfg_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [RANGE_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } lsps_mem_req_t;

  typedef logic [CHORD_W-1:0] chord_tab_t [MAX_SAMPLES];

  // restoring long division, only evaluated while building the table
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // 2*tan(step*w/2) in Q2.CHORD_FRAC_BITS, q30 series for sine and cosine
  function automatic logic [CHORD_W-1:0] chord_entry(input int w);
    logic [63:0] sat;
    logic [63:0] hh;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sp;
    logic [63:0] sn;
    logic [63:0] cp;
    logic [63:0] cn;
    logic [63:0] s;
    logic [63:0] c;
    logic [63:0] q;
    logic        done;
    sat  = (64'd1 << CHORD_W) - 64'd1;
    hh   = 64'(ANGLE_STEP_URAD) * 64'(w);
    if (hh >= 64'd3141592) begin
      return sat[CHORD_W-1:0];
    end
    x    = ((hh << 29) + 64'd500000) / 64'd1000000;
    term = x;
    sp   = x;
    sn   = '0;
    cp   = 64'd1 << 30;
    cn   = '0;
    done = 1'b0;
    for (int n = 2; n <= 26; n++) begin
      if (!done) begin
        term = div_u64((term * x) >> 30, 64'(n));
        if (term == 64'd0) begin
          done = 1'b1;
        end else begin
          case (n % 4)
            0:       cp = cp + term;
            1:       sp = sp + term;
            2:       cn = cn + term;
            default: sn = sn + term;
          endcase
        end
      end
    end
    s = (sp > sn) ? sp - sn : 64'd0;
    c = (cp > cn) ? cp - cn : 64'd0;
    if (c == 64'd0) begin
      return sat[CHORD_W-1:0];
    end
    q = div_u64((s << (CHORD_FRAC_BITS + 1)) + (c >> 1), c);
    return (q > sat) ? sat[CHORD_W-1:0] : q[CHORD_W-1:0];
  endfunction

  function automatic chord_tab_t build_chord_tab();
    chord_tab_t tab;
    for (int w = 0; w < MAX_SAMPLES; w++) begin
      tab[w] = chord_entry(w);
    end
    return tab;
  endfunction

endpackage

// ===== rtl/lsps_cfg_regs.sv =====
// configuration register bank
module lsps_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lsps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output lsps_pkg::lsps_cfg_t          cfg_o
);
  import lsps_pkg::*;

  lsps_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_clamp_mm    <= RST_RANGE_CLAMP;
      cfg_q.edge_threshold_mm <= RST_EDGE_THR;
      cfg_q.min_chord_mm      <= RST_MIN_CHORD;
      cfg_q.max_chord_mm      <= RST_MAX_CHORD;
      cfg_q.scan_length       <= RST_SCAN_LEN;
      cfg_q.centre_window     <= RST_CENTRE_WIN;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RANGE_CLAMP: cfg_q.range_clamp_mm    <= cfg_data_i[RANGE_W-1:0];
        CFG_EDGE_THR:    cfg_q.edge_threshold_mm <= cfg_data_i[THR_W-1:0];
        CFG_MIN_CHORD:   cfg_q.min_chord_mm      <= cfg_data_i[RANGE_W-1:0];
        CFG_MAX_CHORD:   cfg_q.max_chord_mm      <= cfg_data_i[RANGE_W-1:0];
        CFG_SCAN_LEN:    cfg_q.scan_length       <= cfg_data_i[LEN_W-1:0];
        CFG_CENTRE_WIN:  cfg_q.centre_window     <= cfg_data_i[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/lsps_sample_mem.sv =====
// sample store, one write and one registered read port
module lsps_sample_mem (
  input  logic                          clk_i,
  input  lsps_pkg::lsps_mem_req_t       req_i,
  output logic [lsps_pkg::RANGE_W-1:0]  rd_data_o
);
  import lsps_pkg::*;

  logic [RANGE_W-1:0] store_q [MAX_SAMPLES];
  logic [RANGE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      store_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= store_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/lsps_chord_rom.sv =====
// chord factor rom indexed by segment width, registered read
module lsps_chord_rom (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [lsps_pkg::ADDR_W-1:0]   rd_addr_i,
  output logic [lsps_pkg::CHORD_W-1:0]  rd_data_o
);
  import lsps_pkg::*;

  localparam chord_tab_t ChordTab = build_chord_tab();

  logic [CHORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= ChordTab[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/lsps_seg_core.sv =====
// edge finder, five-tap average and chord check sequencer
module lsps_seg_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsps_pkg::lsps_cfg_t           cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lsps_pkg::lsps_in_t            in_data_i,
  output lsps_pkg::lsps_mem_req_t       mem_req_o,
  input  logic [lsps_pkg::RANGE_W-1:0]  mem_rdata_i,
  output logic                          rom_en_o,
  output logic [lsps_pkg::ADDR_W-1:0]   rom_addr_o,
  input  logic [lsps_pkg::CHORD_W-1:0]  rom_data_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output lsps_pkg::lsps_out_t           res_o
);
  import lsps_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_MEAN,
    ST_CHORD,
    ST_CHECK,
    ST_EMIT
  } state_e;

  localparam int TAP_W  = ADDR_W + 2;
  localparam int PROD_W = 2 * SUM_W;
  localparam int CPR_W  = CHORD_W + RANGE_W;
  localparam int CHD_W  = CPR_W - CHORD_FRAC_BITS;
  localparam logic [2:0] TAPS = 3'd5;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [RANGE_W-1:0]  prev_q, prev_d;
  logic                open_q, open_d;
  logic [ADDR_W-1:0]   fall_q, fall_d;
  logic [CNT_W-1:0]    total_q, total_d;
  logic                last_q, last_d;
  logic [ADDR_W-1:0]   centre_q, centre_d;
  logic [ADDR_W-1:0]   width_q, width_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [RANGE_W-1:0]  mean_q, mean_d;
  logic [CPR_W-1:0]    cprod_q, cprod_d;
  lsps_out_t           res_q, res_d;

  logic                acc;
  logic [RANGE_W-1:0]  r;
  logic                in_span;
  logic                fall_hit;
  logic                rise_hit;
  logic [ADDR_W-1:0]   e;
  logic [ADDR_W:0]     csum;
  logic [ADDR_W-1:0]   centre;
  logic [ADDR_W-1:0]   width;
  logic [WIN_W-1:0]    mid;
  logic                in_win;
  logic [TAP_W-1:0]    tap;
  logic [CHD_W-1:0]    chord;
  logic                ok;
  logic [CNT_W-1:0]    tot_inc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign acc         = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == ST_EMIT);
  assign res_o       = res_q;

  // edge finder datapath on the incoming sample
  always_comb begin
    r = (in_data_i.invalid || (in_data_i.range_mm > cfg_i.range_clamp_mm))
        ? cfg_i.range_clamp_mm : in_data_i.range_mm;
    in_span  = (idx_q < IDX_W'(MAX_SAMPLES));
    fall_hit = {2'b00, prev_q} > ({2'b00, r} + {5'd0, cfg_i.edge_threshold_mm});
    rise_hit = {2'b00, r} > ({2'b00, prev_q} + {5'd0, cfg_i.edge_threshold_mm});
    e        = idx_q[ADDR_W-1:0] - ADDR_W'(1);
    csum     = {1'b0, fall_q} + {1'b0, e};
    centre   = csum[ADDR_W:1];
    width    = e - fall_q;
    mid      = cfg_i.scan_length[LEN_W-1:1];
    in_win   = (({2'b00, centre} + {2'b00, cfg_i.centre_window}) > {2'b00, mid})
               && ({2'b00, centre} < ({2'b00, mid} + {2'b00, cfg_i.centre_window}));
  end

  // tap address, clamped to zero below the first beam
  always_comb begin
    tap = {2'b00, centre_q} + {{(TAP_W-3){1'b0}}, cnt_q};
    if (tap < TAP_W'(2)) begin
      tap = '0;
    end else begin
      tap = tap - TAP_W'(2);
    end
  end

  always_comb begin
    chord   = cprod_q[CPR_W-1:CHORD_FRAC_BITS];
    ok      = (chord > {2'b00, cfg_i.min_chord_mm}) && (chord < {2'b00, cfg_i.max_chord_mm});
    tot_inc = (total_q != {CNT_W{1'b1}}) ? total_q + CNT_W'(1) : total_q;
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    prev_d   = prev_q;
    open_d   = open_q;
    fall_d   = fall_q;
    total_d  = total_q;
    last_d   = last_q;
    centre_d = centre_q;
    width_d  = width_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    prod_d   = prod_q;
    mean_d   = mean_q;
    cprod_d  = cprod_q;
    res_d    = res_q;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = idx_q[ADDR_W-1:0];
    mem_req_o.wdata = r;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = tap[ADDR_W-1:0];
    rom_en_o        = 1'b0;
    rom_addr_o      = width;

    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          last_d = in_data_i.last;
          if (in_span) begin
            mem_req_o.we = 1'b1;
            if (idx_q != '0) begin
              if (fall_hit) begin
                open_d = 1'b1;
                fall_d = e;
              end else if (open_q && rise_hit) begin
                open_d = 1'b0;
                if (in_win) begin
                  // segment closed near mid-scan: fetch rom and five taps
                  rom_en_o = 1'b1;
                  centre_d = centre;
                  width_d  = width;
                  cnt_d    = '0;
                  sum_d    = '0;
                  state_d  = ST_AVG;
                end
              end
            end
            prev_d = r;
            idx_d  = idx_q + IDX_W'(1);
          end
          if (in_data_i.last) begin
            idx_d  = '0;
            open_d = 1'b0;
          end
          if (in_data_i.last && (state_d == ST_IDLE)) begin
            res_d.kind           = KIND_END;
            res_d.centre_index   = '0;
            res_d.seg_width      = '0;
            res_d.mean_range_mm  = '0;
            res_d.accepted_count = total_q;
            total_d              = '0;
            state_d              = ST_EMIT;
          end
        end
      end
      ST_AVG: begin
        // read issued while cnt below five, data lands on the next beat
        mem_req_o.re = (cnt_q < TAPS);
        if (cnt_q != 3'd0) begin
          sum_d = sum_q + {3'b000, mem_rdata_i};
        end
        if (cnt_q == TAPS) begin
          state_d = ST_MEAN;
        end
        cnt_d = cnt_q + 3'd1;
      end
      ST_MEAN: begin
        prod_d  = sum_q * MEAN_RECIP;
        state_d = ST_CHORD;
      end
      ST_CHORD: begin
        mean_d  = prod_q[MEAN_SHIFT+RANGE_W-1:MEAN_SHIFT];
        cprod_d = rom_data_i * prod_q[MEAN_SHIFT+RANGE_W-1:MEAN_SHIFT];
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (ok) begin
          total_d = tot_inc;
        end
        if (ok || last_q) begin
          res_d.kind           = last_q ? KIND_END : KIND_CAND;
          res_d.centre_index   = ok ? centre_q : '0;
          res_d.seg_width      = ok ? width_q : '0;
          res_d.mean_range_mm  = ok ? mean_q : '0;
          res_d.accepted_count = ok ? tot_inc : total_q;
          if (last_q) begin
            total_d = '0;
          end
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      prev_q  <= '0;
      open_q  <= 1'b0;
      fall_q  <= '0;
      total_q <= '0;
      last_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      prev_q  <= prev_d;
      open_q  <= open_d;
      fall_q  <= fall_d;
      total_q <= total_d;
      last_q  <= last_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    centre_q <= centre_d;
    width_q  <= width_d;
    sum_q    <= sum_d;
    prod_q   <= prod_d;
    mean_q   <= mean_d;
    cprod_q  <= cprod_d;
    res_q    <= res_d;
  end

endmodule

// ===== rtl/laser_scan_person_segmenter_top.sv =====
// top level of the laser scan person segmenter
//
// One range sample per input beat (range in mm, invalid flag, last flag) on
// in_valid_i/in_ready_o. Results leave on out_valid_o/out_ready_i: kind 0 is
// an accepted person candidate, kind 1 closes the scan with the candidate
// count. Registers are written on cfg_valid_i at cfg_index_i, always ready.
// A plain sample does its store write and edge step in the same beat.
// A segment that closes inside the centre window runs the five averaging
// reads through the single read port of the sample memory, then the mean
// multiply, chord multiply and compare stages, plus the emit stage when it
// yields a result.
// A last sample that starts no chord check goes straight to the emit stage.
// A result reaches out_valid_o through the output register once the
// sequencer emits it and that register is free.
// The output register frees the sequencer, so input keeps flowing while a
// result waits; a second result stalls the sequencer until the first is taken.
// Reset clears control state and loads the register defaults; the sample
// memory needs no clearing since a scan only reads beams it wrote itself.
module laser_scan_person_segmenter_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lsps_pkg::lsps_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lsps_pkg::lsps_out_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lsps_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lsps_pkg::*;

  lsps_cfg_t          cfg;
  lsps_mem_req_t      mem_req;
  logic [RANGE_W-1:0] mem_rdata;
  logic               rom_en;
  logic [ADDR_W-1:0]  rom_addr;
  logic [CHORD_W-1:0] rom_data;
  logic               res_valid;
  logic               res_ready;
  lsps_out_t          res;

  logic               out_valid_q;
  lsps_out_t          out_q;

  assign cfg_ready_o = 1'b1;

  lsps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lsps_sample_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rdata)
  );

  lsps_chord_rom u_rom (
    .clk_i     (clk_i),
    .rd_en_i   (rom_en),
    .rd_addr_i (rom_addr),
    .rd_data_o (rom_data)
  );

  lsps_seg_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .rom_en_o    (rom_en),
    .rom_addr_o  (rom_addr),
    .rom_data_i  (rom_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // averaging reads only run while the input side is held off
  a_read_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.re |-> !in_ready_o)
    else $error("sample read while input is open");

  // a pending result that cannot move stays put
  a_res_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed while stalled");

  // a candidate always counts itself
  a_cand_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KIND_CAND) |-> out_data_o.accepted_count != '0)
    else $error("candidate emitted with zero count");

endmodule

// ===== tb/laser_scan_person_segmenter_top_test.sv =====
// self-checking testbench for the laser scan person segmenter top level
module laser_scan_person_segmenter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lsps_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 9;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int TIMEOUT_NS   = 4_000_000;
  localparam int PHASE_BEATS  = 65;

  // indexes past the last register, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  class segment_scoreboard;
    logic [RANGE_W-1:0] clamp_mm;
    logic [THR_W-1:0]   thr_mm;
    logic [RANGE_W-1:0] min_mm;
    logic [RANGE_W-1:0] max_mm;
    logic [LEN_W-1:0]   scan_len;
    logic [WIN_W-1:0]   win;
    logic [RANGE_W-1:0] beam_mem [MAX_SAMPLES];
    logic [CHORD_W-1:0] chord_lut [MAX_SAMPLES];
    int                 beam_idx;
    int                 prev_mm;
    bit                 seg_open;
    int                 fall_idx;
    int                 n_accepted;
    lsps_out_t          pending_results [$];
    int                 failures;

    function new();
      for (int w = 0; w < MAX_SAMPLES; w++) begin
        chord_lut[w] = CHORD_W'(tan_factor(w));
        beam_mem[w]  = '0;
      end
      clamp_mm   = RST_RANGE_CLAMP;
      thr_mm     = RST_EDGE_THR;
      min_mm     = RST_MIN_CHORD;
      max_mm     = RST_MAX_CHORD;
      scan_len   = RST_SCAN_LEN;
      win        = RST_CENTRE_WIN;
      beam_idx   = 0;
      prev_mm    = 0;
      seg_open   = 1'b0;
      fall_idx   = 0;
      n_accepted = 0;
      failures   = 0;
    endfunction

    // 2*tan(step*w/2) with CHORD_FRAC_BITS fraction bits, sine and cosine as q30 series
    function longint unsigned tan_factor(int w);
      longint unsigned sat, hh, x, term, sp, sn, cp, cn, s, c, q;
      sat = (64'd1 << CHORD_W) - 64'd1;
      hh  = 64'(ANGLE_STEP_URAD) * 64'(w);
      if (hh >= 64'd3141592) begin
        return sat;
      end
      x    = ((hh << 29) + 64'd500000) / 64'd1000000;
      term = x;
      sp   = x;
      sn   = 0;
      cp   = 64'd1 << 30;
      cn   = 0;
      for (int n = 2; n <= 26; n++) begin
        // once a term reaches zero every later one is zero too
        term = ((term * x) >> 30) / 64'(n);
        if (term != 0) begin
          case (n % 4)
            0:       cp += term;
            1:       sp += term;
            2:       cn += term;
            default: sn += term;
          endcase
        end
      end
      s = (sp > sn) ? sp - sn : 64'd0;
      c = (cp > cn) ? cp - cn : 64'd0;
      if (c == 0) begin
        return sat;
      end
      q = ((s << (CHORD_FRAC_BITS + 1)) + c / 2) / c;
      return (q > sat) ? sat : q;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_RANGE_CLAMP: clamp_mm = data[RANGE_W-1:0];
        CFG_EDGE_THR:    thr_mm   = data[THR_W-1:0];
        CFG_MIN_CHORD:   min_mm   = data[RANGE_W-1:0];
        CFG_MAX_CHORD:   max_mm   = data[RANGE_W-1:0];
        CFG_SCAN_LEN:    scan_len = data[LEN_W-1:0];
        CFG_CENTRE_WIN:  win      = data[WIN_W-1:0];
        default: ;
      endcase
    endfunction

    function int stored_at(int i);
      if (i < 0) begin
        i = 0;
      end
      if (i >= MAX_SAMPLES) begin
        return 0;
      end
      return int'(beam_mem[i]);
    endfunction

    function void note_beam(lsps_in_t beat);
      int r, diff, e, centre, width, mid, sum, mean;
      longint unsigned chord;
      bit hit;
      lsps_out_t res;
      r   = int'(beat.range_mm);
      hit = 1'b0;
      res = '0;
      if (beat.invalid || r > int'(clamp_mm)) begin
        r = int'(clamp_mm);
      end
      // beams past the store are dropped and form no edge
      if (beam_idx < MAX_SAMPLES) begin
        beam_mem[beam_idx] = RANGE_W'(r);
        if (beam_idx > 0) begin
          diff = r - prev_mm;
          e    = beam_idx - 1;
          if (diff < -int'(thr_mm)) begin
            seg_open = 1'b1;
            fall_idx = e;
          end else if (seg_open && diff > int'(thr_mm)) begin
            seg_open = 1'b0;
            centre   = (fall_idx + e) >> 1;
            width    = e - fall_idx;
            mid      = int'(scan_len) >> 1;
            if (centre > mid - int'(win) && centre < mid + int'(win)) begin
              sum = 0;
              for (int k = -2; k <= 2; k++) begin
                sum += stored_at(centre + k);
              end
              mean  = sum / 5;
              chord = (longint'(chord_lut[width]) * longint'(mean)) >> CHORD_FRAC_BITS;
              if (chord > min_mm && chord < max_mm) begin
                hit                = 1'b1;
                res.centre_index   = ADDR_W'(centre);
                res.seg_width      = ADDR_W'(width);
                res.mean_range_mm  = RANGE_W'(mean);
                if (n_accepted < 1023) begin
                  n_accepted++;
                end
              end
            end
          end
        end
        prev_mm = r;
        beam_idx++;
      end
      if (hit || beat.last) begin
        res.kind           = beat.last ? KIND_END : KIND_CAND;
        res.accepted_count = CNT_W'(n_accepted);
        pending_results.push_back(res);
      end
      if (beat.last) begin
        beam_idx   = 0;
        seg_open   = 1'b0;
        n_accepted = 0;
      end
    endfunction

    function void check_result(lsps_out_t got);
      lsps_out_t exp;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("result with nothing pending: kind %0d centre %0d width %0d mean %0d count %0d",
                   got.kind, got.centre_index, got.seg_width, got.mean_range_mm,
                   got.accepted_count);
        end
        return;
      end
      exp = pending_results.pop_front();
      if (got.kind !== exp.kind || got.centre_index !== exp.centre_index ||
          got.seg_width !== exp.seg_width || got.mean_range_mm !== exp.mean_range_mm ||
          got.accepted_count !== exp.accepted_count) begin
        failures++;
        if (failures <= 10) begin
          $display("result mismatch (exp/got): kind %0d/%0d centre %0d/%0d width %0d/%0d",
                   exp.kind, got.kind, exp.centre_index, got.centre_index,
                   exp.seg_width, got.seg_width);
          $display("  mean %0d/%0d count %0d/%0d", exp.mean_range_mm, got.mean_range_mm,
                   exp.accepted_count, got.accepted_count);
        end
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  lsps_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  lsps_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  segment_scoreboard sb;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req   = 1'b0;
  int beats_sent = 0;

  laser_scan_person_segmenter_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 70) begin
      return $urandom_range(3, 1);
    end else if (r < 95) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(80, 20);
  endfunction

  function automatic lsps_in_t beam(input int mm, input bit bad, input bit fin);
    lsps_in_t b;
    b.range_mm = RANGE_W'(mm);
    b.invalid  = bad;
    b.last     = fin;
    return b;
  endfunction

  task automatic send_beat(input lsps_in_t beat);
    int gap;
    gap = (tx_idle_on && $urandom_range(99, 0) < 30) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    sb.note_beam(beat);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    // a segment that closes without a result can still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] clamp, input logic [15:0] thr,
                              input logic [15:0] minc, input logic [15:0] maxc,
                              input logic [15:0] len, input logic [15:0] win);
    wait_drained();
    write_reg(CFG_RANGE_CLAMP, clamp);
    write_reg(CFG_EDGE_THR, thr);
    write_reg(CFG_MIN_CHORD, minc);
    write_reg(CFG_MAX_CHORD, maxc);
    write_reg(CFG_SCAN_LEN, len);
    write_reg(CFG_CENTRE_WIN, win);
    write_reg(CFG_SPARE_LO, 16'($urandom));
    write_reg(CFG_SPARE_HI, 16'($urandom));
  endtask

  // background with one person-like dip placed round mid-scan, sometimes a second dip
  task automatic send_scan(input int len, input int noise_pct, input bit wide);
    int clamp, thr, jit, bg, near, avail, mid, win, w, start, w2, start2, v;
    bit inseg;
    lsps_in_t beat;
    clamp = int'(sb.clamp_mm);
    thr   = int'(sb.thr_mm);
    jit   = thr / 4;
    bg    = ($urandom_range(9, 0) < 4) ? clamp : int'($urandom_range(clamp, clamp / 2));
    avail = bg - jit - thr - 1;
    near  = (avail > 0) ? bg - jit - thr - int'($urandom_range(avail, 1)) : 0;
    mid   = int'(sb.scan_len) >> 1;
    win   = int'(sb.win);
    w     = wide ? int'($urandom_range(700, 512)) : int'($urandom_range(12, 1));
    if (w > len - 3) begin
      w = len - 3;
    end
    if (w < 0) begin
      w = 0;
    end
    start = mid + 1 - w / 2 + int'($urandom_range(2 * win + 4, 0)) - win - 2;
    if (start > len - 1 - w) begin
      start = len - 1 - w;
    end
    if (start < 1) begin
      start = 1;
    end
    w2     = 0;
    start2 = 0;
    if ($urandom_range(9, 0) < 3) begin
      w2     = int'($urandom_range(8, 1));
      start2 = int'($urandom_range(len, 1));
    end
    for (int i = 0; i < len; i++) begin
      inseg = (i >= start && i < start + w) || (i >= start2 && i < start2 + w2);
      v = (inseg ? near : bg) - int'($urandom_range(jit, 0));
      if (v < 0) begin
        v = 0;
      end
      beat.range_mm = RANGE_W'(v);
      beat.invalid  = 1'b0;
      // at the clamp level an over-range or invalid beam reads the same
      if (!inseg && bg == clamp && $urandom_range(9, 0) == 0) begin
        beat.invalid  = 1'($urandom_range(1, 0));
        beat.range_mm = beat.invalid ? RANGE_W'($urandom) : RANGE_W'($urandom_range(65535, clamp));
      end
      if (int'($urandom_range(99, 0)) < noise_pct) begin
        beat.range_mm = RANGE_W'($urandom);
        beat.invalid  = 1'($urandom_range(1, 0));
      end
      beat.last = (i == len - 1);
      send_beat(beat);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(99, 0) < 25) begin
        stall_left = pick_gap() - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int start_beats;
    int len;
    int minc;
    bit paused;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tiny scans round beam zero, mid-scan is beam 2
    program_regs(6000, 500, 0, 16'hFFFF, 4, 8);
    send_beat(beam(5000, 0, 0));     // first beam, no step
    send_beat(beam(6000, 0, 0));     // rise with nothing open
    send_beat(beam(100, 0, 0));
    send_beat(beam(0, 0, 0));
    send_beat(beam(16'hFFFF, 0, 0)); // over clamp, closes segment
    send_beat(beam(0, 1, 0));
    send_beat(beam(300, 0, 0));
    send_beat(beam(16'hFFFF, 1, 1)); // candidate on the last beam
    send_beat(beam(1234, 0, 1));     // one-beam scan
    send_beat(beam(5000, 0, 0));
    send_beat(beam(100, 0, 0));      // falls at beam zero
    send_beat(beam(6000, 0, 0));     // centre at zero, reads below zero
    send_beat(beam(0, 1, 1));
    send_beat(beam(5000, 0, 0));
    send_beat(beam(4500, 0, 0));     // step equal to threshold is no edge
    send_beat(beam(3999, 0, 0));
    send_beat(beam(4499, 0, 0));
    send_beat(beam(4500, 0, 0));
    send_beat(beam(5001, 0, 1));

    // all registers but max chord at the low end
    program_regs(0, 0, 0, 16'hFFFF, 0, 0);
    repeat (3) send_scan(10, 20, 1'b0);

    // all but min chord at the top, masked writes, one scan running past the sample store
    program_regs(16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_scan(MAX_SAMPLES + 6, 2, 1'b1);

    for (int p = 0; p < 6; p++) begin
      minc = $urandom_range(400, 0);
      program_regs(16'(($urandom_range(9, 0) < 7) ? $urandom_range(65535, 3000) : $urandom),
                   16'(($urandom_range(9, 0) < 8) ? $urandom_range(3000, 50) : $urandom),
                   16'((p == 1) ? 65535 : minc),
                   16'((p == 1) ? 0 : minc + int'($urandom_range(3000, 50))),
                   16'($urandom_range(48, 8)), 16'(0));
      write_reg(CFG_CENTRE_WIN, 16'($urandom_range(int'(sb.scan_len) / 2 + 2, 1)));
      tx_idle_on  = (p % 3 != 0);
      rx_idle_on  = (p % 3 != 0);
      start_beats = beats_sent;
      paused      = 1'b0;
      if (p == 2) begin
        // long output stall while beams keep coming
        hold_req = 1'b1;
      end
      while (beats_sent - start_beats < PHASE_BEATS) begin
        if (p == 4 && !paused && beats_sent - start_beats >= PHASE_BEATS / 2) begin
          paused = 1'b1;
          wait_drained();
        end
        len = int'(sb.scan_len) + int'($urandom_range(4, 0)) - 2;
        if ($urandom_range(9, 0) == 0) begin
          len = $urandom_range(3, 1);
        end
        if (len < 1) begin
          len = 1;
        end
        send_scan(len, ($urandom_range(99, 0) < 15) ? 100 : 5, 1'b0);
      end
    end

    wait_drained();
    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
